### sv/lzwe_pkg.sv
// Shared types and constants for the LZW byte encoder.
`timescale 1ns / 1ps
`default_nettype none

package lzwe_pkg;

    localparam int BYTE_W        = 8;
    localparam int CODE_FIELD_W  = 12;
    localparam int ROOT_CODES    = 256;
    localparam int DICT_SIZE_DEF = 4096;
    localparam int CODE_BITS_DEF = 12;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_WALK,
        S_MISS,
        S_LINK,
        S_FLUSH
    } state_t;

    typedef struct packed {
        logic                    last;
        logic [CODE_FIELD_W-1:0] code;
    } result_t;

endpackage

`default_nettype wire

### sv/lzw_byte_encoder.sv
// Steps: a first byte of a stream only becomes the prefix; each other byte reads the
//   prefix's entry, then walks its child list node by node (up to 256), then on a miss
//   emits the prefix code and, if the dictionary has room, inserts an entry and links it.
// Throughput: one byte at a time; the child-list walk through the dictionary memory's
//   single read port sets the rate. End of stream flushes the prefix as the last code.
// Reset: control state clears at once; root child links are guarded by 256 valid bits.
`timescale 1ns / 1ps
`default_nettype none

module lzw_byte_encoder #(
    parameter int DICT_SIZE = lzwe_pkg::DICT_SIZE_DEF,
    parameter int CODE_BITS = lzwe_pkg::CODE_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,   // end_of_stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [15:0] m_axis_tdata,   // [11:0] code, [15:12] zero
    output logic             m_axis_tlast    // last_code
);

    localparam int BY_BITS = 1 << CODE_BITS;
    localparam int LIMIT   = (BY_BITS < DICT_SIZE) ? BY_BITS : DICT_SIZE;
    localparam int CDW     = $clog2(LIMIT);
    localparam int DW      = lzwe_pkg::BYTE_W + 2 * CDW;

    lzwe_pkg::state_t state_reg, state_next;

    logic [7:0]     byte_reg, byte_next;
    logic           last_reg, last_next;
    logic [CDW-1:0] prefix_reg, prefix_next;
    logic           prefix_valid_reg, prefix_valid_next;
    logic [CDW:0]   next_free_reg, next_free_next;
    logic [CDW-1:0] cur_reg, cur_next;
    logic [CDW-1:0] phead_reg, phead_next;
    logic [CDW-1:0] psib_reg, psib_next;
    logic [7:0]     pbyte_reg, pbyte_next;
    logic [255:0]   root_valid_reg, root_valid_next;

    logic           rd_en, wr_en;
    logic [CDW-1:0] rd_addr, wr_addr;
    logic [DW-1:0]  rd_data, wr_data;

    logic [7:0]     rd_byte;
    logic [CDW-1:0] rd_sib, rd_head, head_eff;
    logic           prefix_is_root, node_match, room;
    logic [CDW-1:0] byte_code;
    logic [31:0]    prefix_wide;

    logic              fifo_push, fifo_full;
    lzwe_pkg::result_t push_data, pop_data;

    // entry layout from the lowest bit: byte, next sibling, first child (0 = none)
    assign rd_byte = rd_data[7:0];
    assign rd_sib  = rd_data[8 +: CDW];
    assign rd_head = rd_data[8 + CDW +: CDW];

    assign prefix_is_root = (prefix_reg[CDW-1:8] == '0);
    assign head_eff       = (prefix_is_root && !root_valid_reg[prefix_reg[7:0]]) ? '0 : rd_head;
    assign node_match     = (rd_byte == byte_reg);
    assign room           = (next_free_reg < (CDW+1)'(LIMIT));
    assign byte_code      = {{(CDW-8){1'b0}}, byte_reg};
    assign prefix_wide    = 32'(prefix_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lzwe_pkg::S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (prefix_valid_reg)
                    begin
                        state_next = lzwe_pkg::S_HEAD;
                    end
                    else if (s_axis_tlast)
                    begin
                        state_next = lzwe_pkg::S_FLUSH;
                    end
                end
            end
            lzwe_pkg::S_HEAD:
            begin
                state_next = (head_eff == '0) ? lzwe_pkg::S_MISS : lzwe_pkg::S_WALK;
            end
            lzwe_pkg::S_WALK:
            begin
                if (node_match)
                begin
                    state_next = last_reg ? lzwe_pkg::S_FLUSH : lzwe_pkg::S_IDLE;
                end
                else if (rd_sib == '0)
                begin
                    state_next = lzwe_pkg::S_MISS;
                end
            end
            lzwe_pkg::S_MISS:
            begin
                if (!fifo_full)
                begin
                    if (room)
                    begin
                        state_next = lzwe_pkg::S_LINK;
                    end
                    else
                    begin
                        state_next = last_reg ? lzwe_pkg::S_FLUSH : lzwe_pkg::S_IDLE;
                    end
                end
            end
            lzwe_pkg::S_LINK:
            begin
                state_next = last_reg ? lzwe_pkg::S_FLUSH : lzwe_pkg::S_IDLE;
            end
            lzwe_pkg::S_FLUSH:
            begin
                if (!fifo_full)
                begin
                    state_next = lzwe_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lzwe_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        s_axis_tready     = 1'b0;
        byte_next         = byte_reg;
        last_next         = last_reg;
        prefix_next       = prefix_reg;
        prefix_valid_next = prefix_valid_reg;
        next_free_next    = next_free_reg;
        cur_next          = cur_reg;
        phead_next        = phead_reg;
        psib_next         = psib_reg;
        pbyte_next        = pbyte_reg;
        root_valid_next   = root_valid_reg;
        rd_en             = 1'b0;
        rd_addr           = prefix_reg;
        wr_en             = 1'b0;
        wr_addr           = prefix_reg;
        wr_data           = {next_free_reg[CDW-1:0], psib_reg, pbyte_reg};
        fifo_push         = 1'b0;
        push_data.code    = prefix_wide[lzwe_pkg::CODE_FIELD_W-1:0];
        push_data.last    = 1'b0;
        unique case (state_reg)
            lzwe_pkg::S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    byte_next = s_axis_tdata;
                    last_next = s_axis_tlast;
                    if (!prefix_valid_reg)
                    begin
                        prefix_next       = {{(CDW-8){1'b0}}, s_axis_tdata};
                        prefix_valid_next = 1'b1;
                    end
                    else
                    begin
                        rd_en = 1'b1;
                    end
                end
            end
            lzwe_pkg::S_HEAD:
            begin
                // keep the prefix entry for the later child-link update
                pbyte_next = rd_byte;
                psib_next  = rd_sib;
                phead_next = head_eff;
                if (head_eff != '0)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = head_eff;
                    cur_next = head_eff;
                end
            end
            lzwe_pkg::S_WALK:
            begin
                if (node_match)
                begin
                    prefix_next = cur_reg;
                end
                else if (rd_sib != '0)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = rd_sib;
                    cur_next = rd_sib;
                end
            end
            lzwe_pkg::S_MISS:
            begin
                if (!fifo_full)
                begin
                    fifo_push = 1'b1;
                    if (room)
                    begin
                        // new node goes to the head of the prefix's child list
                        wr_en   = 1'b1;
                        wr_addr = next_free_reg[CDW-1:0];
                        wr_data = {{CDW{1'b0}}, phead_reg, byte_reg};
                    end
                    else
                    begin
                        prefix_next = byte_code;
                    end
                end
            end
            lzwe_pkg::S_LINK:
            begin
                wr_en = 1'b1;
                if (prefix_is_root)
                begin
                    root_valid_next[prefix_reg[7:0]] = 1'b1;
                end
                next_free_next = next_free_reg + (CDW+1)'(1);
                prefix_next    = byte_code;
            end
            lzwe_pkg::S_FLUSH:
            begin
                push_data.last = 1'b1;
                if (!fifo_full)
                begin
                    fifo_push         = 1'b1;
                    prefix_next       = '0;
                    prefix_valid_next = 1'b0;
                    next_free_next    = (CDW+1)'(lzwe_pkg::ROOT_CODES);
                    root_valid_next   = '0;
                end
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= lzwe_pkg::S_IDLE;
            prefix_reg       <= '0;
            prefix_valid_reg <= 1'b0;
            next_free_reg    <= (CDW+1)'(lzwe_pkg::ROOT_CODES);
            root_valid_reg   <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            prefix_reg       <= prefix_next;
            prefix_valid_reg <= prefix_valid_next;
            next_free_reg    <= next_free_next;
            root_valid_reg   <= root_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        last_reg  <= last_next;
        cur_reg   <= cur_next;
        phead_reg <= phead_next;
        psib_reg  <= psib_next;
        pbyte_reg <= pbyte_next;
    end

    lzwe_dict_ram #(
        .DEPTH (LIMIT),
        .AW    (CDW),
        .DW    (DW)
    ) u_dict (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    lzwe_out_fifo u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fifo_push),
        .push_data (push_data),
        .full      (fifo_full),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (pop_data)
    );

    assign m_axis_tdata = {{(16 - lzwe_pkg::CODE_FIELD_W){1'b0}}, pop_data.code};
    assign m_axis_tlast = pop_data.last;

    a_free_code_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        next_free_reg <= (CDW+1)'(LIMIT))
        else $error("next free code beyond dictionary limit");

    a_no_read_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && wr_en))
        else $error("dictionary read and write in the same cycle");

    a_head_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lzwe_pkg::S_HEAD) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("prefix lookup started without an accepted byte");

    a_flush_clears_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lzwe_pkg::S_FLUSH && !fifo_full)
            |=> (!prefix_valid_reg && next_free_reg == (CDW+1)'(lzwe_pkg::ROOT_CODES)))
        else $error("end of stream did not restart the dictionary");

endmodule

`default_nettype wire

### sv/lzwe_dict_ram.sv
// Single-port-write, registered-read dictionary memory.
`timescale 1ns / 1ps
`default_nettype none

module lzwe_dict_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 32
) (
    input  wire logic          clk,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### sv/lzwe_out_fifo.sv
// Two-entry result queue between the encoder core and the output stream.
`timescale 1ns / 1ps
`default_nettype none

module lzwe_out_fifo (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire lzwe_pkg::result_t push_data,
    output logic                  full,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output lzwe_pkg::result_t     out_data
);

    lzwe_pkg::result_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire
